// ===== rtl/core/bpkm_tlv_pkg.sv =====
package bpkm_tlv_pkg;

  localparam int NEST_DEPTH  = 4;
  localparam int OFFSET_BITS = 16;

  localparam int POS_W      = OFFSET_BITS + 1;
  localparam int SUM_W      = ((POS_W > 16) ? POS_W : 16) + 1;
  localparam int LVL_W      = $clog2(NEST_DEPTH + 1);
  localparam int STK_IDX_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_LEN_LO  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_SKIP      = 2'd0;
  localparam logic [1:0] KIND_LEAF      = 2'd1;
  localparam logic [1:0] KIND_CONTAINER = 2'd2;
  localparam logic [1:0] KIND_OTHER     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_OVERRUN   = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_TOO_DEEP  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  attr_type;
    logic [15:0] attr_length;
    logic [15:0] attr_offset;
    logic [2:0]  nest_level;
    logic [1:0]  attr_kind;
    logic [31:0] leaf_value;
    logic [2:0]  status;
    logic        run_last;
  } out_item_t;

  function automatic logic [1:0] kind_of(input logic [7:0] t);
    logic [1:0] k;
    unique case (t)
      8'd0, 8'd14:                                   k = KIND_SKIP;
      8'd5, 8'd13, 8'd19, 8'd23, 8'd25, 8'd28:       k = KIND_CONTAINER;
      8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10,
      8'd11, 8'd12, 8'd15, 8'd16, 8'd17, 8'd18, 8'd20, 8'd21,
      8'd22, 8'd24, 8'd26, 8'd27:                     k = KIND_LEAF;
      default:                                        k = KIND_OTHER;
    endcase
    return k;
  endfunction

  // fixed-size leaf types and their allowed lengths
  function automatic logic length_ok(input logic [7:0] t, input logic [15:0] len);
    logic ok;
    unique case (t)
      8'd2:                             ok = (len == 16'd3);
      8'd3:                             ok = (len == 16'd6);
      8'd7:                             ok = (len == 16'd96) || (len == 16'd128) ||
                                             (len == 16'd256);
      8'd8, 8'd15:                      ok = (len == 16'd8) || (len == 16'd16);
      8'd9, 8'd27:                      ok = (len == 16'd4);
      8'd10, 8'd16, 8'd22, 8'd24, 8'd26: ok = (len == 16'd1);
      8'd11:                            ok = (len == 16'd20);
      8'd12, 8'd20:                     ok = (len == 16'd2);
      default:                          ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/core/bpkm_tlv_attribute_parser.sv =====
// channel  | ports                          | moves
// ---------+--------------------------------+--------------------------------------
// input    | in_valid, in_stall, in_item    | one message byte per request
// result   | out_valid, out_stall, out_item | one attribute report per request
//
// one byte is parsed per cycle; the parse state updates in the accepting cycle and
// its reports (zero, one or two) land in a four-entry result queue.
// in_stall rises while fewer than two queue slots are free, so a byte is taken
// every cycle as long as results drain at least as fast as they are made.
// rst_n is synchronous, active low; it clears the parse state and the queue.
module bpkm_tlv_attribute_parser
  import bpkm_tlv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  phase_t             phase_r, phase_nxt;
  logic [7:0]         cur_type_r, cur_type_nxt;
  logic [15:0]        cur_len_r, cur_len_nxt;
  logic [15:0]        remaining_r, remaining_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   type_off_r, type_off_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic [31:0]        value_r, value_nxt;
  logic               discard_r, discard_nxt;
  logic [POS_W-1:0]   stack_r [NEST_DEPTH];

  out_item_t             fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;

  logic                  in_fire, out_fire;
  logic [7:0]            b;
  logic [POS_W-1:0]      nxt;
  logic                  has_top;
  logic [POS_W-1:0]      top;
  logic [15:0]           len_lo;
  logic [SUM_W-1:0]      end_sum;
  logic [POS_W-1:0]      end_sat;
  logic                  push_en;
  logic [LVL_W-1:0]      level_mid;
  logic [LVL_W-1:0]      level_closed;
  logic [POS_W-1:0]      stk_a;
  logic [1:0]            cur_kind;
  logic                  r0_v, r1_v;
  out_item_t             r0, r1, push0, push1;
  logic                  push_any, push_two;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (count_r > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_item  = fifo_r[rd_ptr_r];

  assign b        = in_item.data_byte;
  assign nxt      = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : POS_MAX;
  assign has_top  = (level_r != '0);
  assign top      = stack_r[STK_IDX_W'(level_r - LVL_W'(1))];
  assign len_lo   = cur_len_r | {8'h00, b};
  assign end_sum  = SUM_W'(nxt) + SUM_W'(len_lo);
  assign end_sat  = (end_sum > SUM_W'(POS_MAX)) ? POS_MAX : POS_W'(end_sum);
  assign cur_kind = kind_of(cur_type_r);

  always_comb begin
    phase_nxt     = phase_r;
    cur_type_nxt  = cur_type_r;
    cur_len_nxt   = cur_len_r;
    remaining_nxt = remaining_r;
    type_off_nxt  = type_off_r;
    value_nxt     = value_r;
    discard_nxt   = discard_r;
    pos_nxt       = nxt;
    push_en       = 1'b0;
    r0_v          = 1'b0;
    r0            = '0;
    r0.status     = ST_OK;
    r0.attr_kind  = cur_kind;

    if (!discard_r) begin
      if ((phase_r == PH_LEN_HI || phase_r == PH_LEN_LO) && has_top && nxt > top) begin
        r0_v        = 1'b1;
        r0.status   = ST_OVERRUN;
        discard_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_TYPE: begin
            cur_type_nxt = b;
            cur_len_nxt  = '0;
            type_off_nxt = pos_r;
            phase_nxt    = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            cur_len_nxt = {b, 8'h00};
            phase_nxt   = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            cur_len_nxt = len_lo;
            priority if (!length_ok(cur_type_r, len_lo)) begin
              r0_v        = 1'b1;
              r0.status   = ST_BAD_LEN;
              discard_nxt = 1'b1;
            end else if (has_top && end_sat > top) begin
              r0_v        = 1'b1;
              r0.status   = ST_OVERRUN;
              discard_nxt = 1'b1;
            end else if (cur_kind == KIND_CONTAINER &&
                         level_r >= LVL_W'(NEST_DEPTH)) begin
              r0_v        = 1'b1;
              r0.status   = ST_TOO_DEEP;
              discard_nxt = 1'b1;
            end else if (cur_kind == KIND_CONTAINER) begin
              r0_v      = 1'b1;
              push_en   = 1'b1;
              phase_nxt = PH_TYPE;
            end else if (len_lo == 16'd0) begin
              r0_v      = 1'b1;
              phase_nxt = PH_TYPE;
            end else begin
              remaining_nxt = len_lo;
              value_nxt     = '0;
              phase_nxt     = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            value_nxt     = {value_r[23:0], b};
            remaining_nxt = remaining_r - 16'd1;
            if (remaining_nxt == 16'd0) begin
              r0_v          = 1'b1;
              r0.leaf_value = (cur_kind == KIND_SKIP) ? 32'd0 : value_nxt;
              phase_nxt     = PH_TYPE;
            end
          end
          default: ;
        endcase
      end
    end

    r0.attr_type   = cur_type_r;
    r0.attr_length = cur_len_nxt;
    r0.attr_offset = 16'(type_off_r);
    r0.nest_level  = 3'(level_r);
  end

  // open ends shrink with depth, so closing is a count of ends still ahead
  always_comb begin
    level_mid    = push_en ? level_r + LVL_W'(1) : level_r;
    level_closed = '0;
    stk_a        = '0;
    for (int i = 0; i < NEST_DEPTH; i++) begin
      stk_a = (push_en && level_r == LVL_W'(i)) ? end_sat : stack_r[i];
      if (LVL_W'(i) < level_mid && stk_a > nxt) begin
        level_closed = level_closed + LVL_W'(1);
      end
    end
    if (!discard_r && !discard_nxt && phase_nxt == PH_TYPE) begin
      level_nxt = level_closed;
    end else begin
      level_nxt = level_mid;
    end
  end

  // truncation report on the final byte
  always_comb begin
    r1_v = in_item.message_end && !discard_nxt &&
           (phase_nxt != PH_TYPE || level_nxt != '0);
    r1             = '0;
    r1.attr_type   = cur_type_nxt;
    r1.attr_length = cur_len_nxt;
    r1.attr_offset = 16'(type_off_nxt);
    r1.nest_level  = 3'(level_nxt);
    r1.attr_kind   = kind_of(cur_type_nxt);
    r1.leaf_value  = '0;
    r1.status      = ST_TRUNCATED;
    r1.run_last    = 1'b1;

    push_two       = r0_v && r1_v;
    push_any       = r0_v || r1_v;
    push0          = r0_v ? r0 : r1;
    push0.run_last = !push_two;
    push1          = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      cur_type_r  <= '0;
      cur_len_r   <= '0;
      remaining_r <= '0;
      pos_r       <= '0;
      type_off_r  <= '0;
      level_r     <= '0;
      value_r     <= '0;
      discard_r   <= 1'b0;
    end else if (in_fire) begin
      if (in_item.message_end) begin
        phase_r     <= PH_TYPE;
        cur_type_r  <= '0;
        cur_len_r   <= '0;
        remaining_r <= '0;
        pos_r       <= '0;
        type_off_r  <= '0;
        level_r     <= '0;
        value_r     <= '0;
        discard_r   <= 1'b0;
      end else begin
        phase_r     <= phase_nxt;
        cur_type_r  <= cur_type_nxt;
        cur_len_r   <= cur_len_nxt;
        remaining_r <= remaining_nxt;
        pos_r       <= pos_nxt;
        type_off_r  <= type_off_nxt;
        level_r     <= level_nxt;
        value_r     <= value_nxt;
        discard_r   <= discard_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && push_en) begin
      stack_r[STK_IDX_W'(level_r)] <= end_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire && push_any) begin
        wr_ptr_r <= push_two ? wr_ptr_r + FIFO_PTR_W'(2) : wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      count_r <= count_r
               + ((in_fire && push_any) ? FIFO_CNT_W'(1) : FIFO_CNT_W'(0))
               + ((in_fire && push_two) ? FIFO_CNT_W'(1) : FIFO_CNT_W'(0))
               - (out_fire ? FIFO_CNT_W'(1) : FIFO_CNT_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && push_any) begin
      fifo_r[wr_ptr_r] <= push0;
    end
    if (in_fire && push_two) begin
      fifo_r[wr_ptr_r + FIFO_PTR_W'(1)] <= push1;
    end
  end

endmodule
